// ===== rtl/core/dbpm_pkg.sv =====
// Shared types and constants of the diagonal band penalty mask.
package dbpm_pkg;

   // Field widths of the stream payloads and the configuration registers.
   localparam int SIM_W    = 32;
   localparam int MASK_W   = 31;
   localparam int COUNT_W  = 13;
   localparam int COLUMN_W = 14;
   localparam int HALF_W   = 12;
   localparam int WEIGHT_W = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // Fixed-point format of the mask and the weight.
   localparam int FRAC_BITS = 16;
   localparam logic [MASK_W-1:0] MASK_ONE = MASK_W'(1) << FRAC_BITS;
   localparam logic [MASK_W-1:0] MASK_MAX = '1;

   // Band geometry widths: column differences, line terms and their magnitudes.
   localparam int A_W    = 14;
   localparam int DIFF_W = 15;
   localparam int PROD_W = 31;
   localparam int MAG_W  = PROD_W - 1;

   // Inverse line length (unsigned Q1.31) and the sequencer that computes it.
   localparam int INV_W       = 32;
   localparam int INV_FRAC    = 31;
   localparam int SUM_W       = 29;
   localparam int QUOT_W      = 63;
   localparam int RAD_W       = 64;
   localparam int ROOT_W      = 32;
   localparam int REM_SQ_W    = 34;
   localparam int STEP_W      = 6;
   localparam int DIV_STEPS   = 63;
   localparam int SQRT_STEPS  = 32;
   localparam int MUL_W       = 16;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ROW_COUNT,
      REG_COLUMN_COUNT,
      REG_TOP_COLUMN,
      REG_BOTTOM_COLUMN,
      REG_BAND_HALF_WIDTH,
      REG_HARD_MODE,
      REG_PENALTY_WEIGHT
   } reg_index_type;

   // Configuration and the values derived from it.
   typedef struct packed {
      logic [COUNT_W-1:0]         row_count;
      logic [COUNT_W-1:0]         column_count;
      logic                       hard_mode;
      logic signed [WEIGHT_W-1:0] penalty_weight;
      logic signed [A_W-1:0]      a;
      logic signed [DIFF_W-1:0]   d;
      logic [DIFF_W-1:0]          abs_d;
      logic signed [DIFF_W-1:0]   lc;
      logic signed [DIFF_W-1:0]   rc;
      logic signed [PROD_W-1:0]   kl;
      logic signed [PROD_W-1:0]   kr;
      logic [INV_W-1:0]           inverse;
   } cfg_type;

   // One classified cell on its way from the front to the back.
   typedef struct packed {
      logic signed [SIM_W-1:0]  sim;
      logic signed [PROD_W-1:0] nl;
      logic signed [PROD_W-1:0] nr;
      logic                     row_zero;
      logic                     col_inside;
      logic                     last;
   } entry_type;

endpackage

// ===== rtl/core/dbpm_cfg.sv =====
// Configuration registers and the sequencer that derives the band constants.
module dbpm_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dbpm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dbpm_pkg::CSR_DATA_W-1:0]      csr_data,
   output dbpm_pkg::cfg_type                    cfg,
   output logic                                 busy,
   output logic                                 restart
);

   typedef enum logic [2:0] {
      ST_MUL_AA,
      ST_MUL_DD,
      ST_MUL_KL,
      ST_MUL_KR,
      ST_SUM,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } state_type;

   logic [dbpm_pkg::COUNT_W-1:0]           row_count_ff;
   logic [dbpm_pkg::COUNT_W-1:0]           column_count_ff;
   logic signed [dbpm_pkg::COLUMN_W-1:0]   top_column_ff;
   logic signed [dbpm_pkg::COLUMN_W-1:0]   bottom_column_ff;
   logic [dbpm_pkg::HALF_W-1:0]            band_half_width_ff;
   logic                                   hard_mode_ff;
   logic signed [dbpm_pkg::WEIGHT_W-1:0]   penalty_weight_ff;

   state_type                              state_ff, state_in;
   logic [dbpm_pkg::SUM_W-1:0]             aa_ff, aa_in, dd_ff, dd_in, s_ff, s_in;
   logic signed [dbpm_pkg::PROD_W-1:0]     kl_ff, kl_in, kr_ff, kr_in;
   logic [dbpm_pkg::SUM_W-1:0]             rem_ff, rem_in;
   logic [dbpm_pkg::QUOT_W-1:0]            quot_ff, quot_in;
   logic [dbpm_pkg::RAD_W-1:0]             rad_ff, rad_in;
   logic [dbpm_pkg::REM_SQ_W-1:0]          r_ff, r_in;
   logic [dbpm_pkg::ROOT_W-1:0]            root_ff, root_in;
   logic [dbpm_pkg::STEP_W-1:0]            step_ff, step_in;
   logic [dbpm_pkg::INV_W-1:0]             inv_ff, inv_in;

   logic                                   write;
   logic                                   write_ok;
   logic signed [dbpm_pkg::A_W-1:0]        a;
   logic signed [dbpm_pkg::DIFF_W-1:0]     d, lc, rc;
   logic [dbpm_pkg::DIFF_W-1:0]            abs_d;
   logic signed [dbpm_pkg::MUL_W-1:0]      op_x, op_y;
   logic signed [2*dbpm_pkg::MUL_W-1:0]    mul;
   logic [dbpm_pkg::SUM_W-1:0]             sum;
   logic [dbpm_pkg::SUM_W:0]               rem2;
   logic                                   div_ge;
   logic [dbpm_pkg::REM_SQ_W+1:0]          r2, trial;
   logic                                   sq_ge;
   logic [dbpm_pkg::QUOT_W-1:0]            quot_next;
   logic [dbpm_pkg::ROOT_W-1:0]            root_next;

   // Writes are always taken; only indexes on the register list have effect.
   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      write_ok = 1'b0;
      if (write) begin
         case (csr_index)
            dbpm_pkg::REG_ROW_COUNT,
            dbpm_pkg::REG_COLUMN_COUNT,
            dbpm_pkg::REG_TOP_COLUMN,
            dbpm_pkg::REG_BOTTOM_COLUMN,
            dbpm_pkg::REG_BAND_HALF_WIDTH,
            dbpm_pkg::REG_HARD_MODE,
            dbpm_pkg::REG_PENALTY_WEIGHT: write_ok = 1'b1;
            default:                      write_ok = 1'b0;
         endcase
      end
   end

   assign restart = write_ok;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff       <= dbpm_pkg::COUNT_W'(2);
         column_count_ff    <= dbpm_pkg::COUNT_W'(1);
         top_column_ff      <= '0;
         bottom_column_ff   <= '0;
         band_half_width_ff <= '0;
         hard_mode_ff       <= 1'b1;
         penalty_weight_ff  <= '0;
      end else if (write) begin
         case (csr_index)
            dbpm_pkg::REG_ROW_COUNT:
               row_count_ff <= csr_data[dbpm_pkg::COUNT_W-1:0];
            dbpm_pkg::REG_COLUMN_COUNT:
               column_count_ff <= csr_data[dbpm_pkg::COUNT_W-1:0];
            dbpm_pkg::REG_TOP_COLUMN:
               top_column_ff <= signed'(csr_data[dbpm_pkg::COLUMN_W-1:0]);
            dbpm_pkg::REG_BOTTOM_COLUMN:
               bottom_column_ff <= signed'(csr_data[dbpm_pkg::COLUMN_W-1:0]);
            dbpm_pkg::REG_BAND_HALF_WIDTH:
               band_half_width_ff <= csr_data[dbpm_pkg::HALF_W-1:0];
            dbpm_pkg::REG_HARD_MODE:
               hard_mode_ff <= csr_data[0];
            dbpm_pkg::REG_PENALTY_WEIGHT:
               penalty_weight_ff <= signed'(csr_data[dbpm_pkg::WEIGHT_W-1:0]);
            default: ;
         endcase
      end
   end

   // Line geometry: row span, column drift and the two boundary columns at row zero.
   assign a     = signed'({1'b0, row_count_ff}) - dbpm_pkg::A_W'(1);
   assign d     = dbpm_pkg::DIFF_W'(bottom_column_ff) - dbpm_pkg::DIFF_W'(top_column_ff);
   assign abs_d = (d < 0) ? dbpm_pkg::DIFF_W'(-d) : dbpm_pkg::DIFF_W'(d);
   assign lc    = dbpm_pkg::DIFF_W'(top_column_ff)
                  - dbpm_pkg::DIFF_W'(signed'({1'b0, band_half_width_ff}));
   assign rc    = dbpm_pkg::DIFF_W'(top_column_ff)
                  + dbpm_pkg::DIFF_W'(signed'({1'b0, band_half_width_ff}));

   // One multiplier shared by the four product steps.
   always_comb begin
      case (state_ff)
         ST_MUL_AA: begin
            op_x = dbpm_pkg::MUL_W'(a);
            op_y = dbpm_pkg::MUL_W'(a);
         end
         ST_MUL_DD: begin
            op_x = dbpm_pkg::MUL_W'(d);
            op_y = dbpm_pkg::MUL_W'(d);
         end
         ST_MUL_KL: begin
            op_x = dbpm_pkg::MUL_W'(a);
            op_y = dbpm_pkg::MUL_W'(lc);
         end
         ST_MUL_KR: begin
            op_x = dbpm_pkg::MUL_W'(a);
            op_y = dbpm_pkg::MUL_W'(rc);
         end
         default: begin
            op_x = '0;
            op_y = '0;
         end
      endcase
   end

   assign mul = op_x * op_y;
   assign sum = aa_ff + dd_ff;

   // Restoring division of 2^62 by the squared line length, one quotient bit a step.
   assign rem2      = {rem_ff, (step_ff == dbpm_pkg::STEP_W'(dbpm_pkg::DIV_STEPS - 1))};
   assign div_ge    = rem2 >= {1'b0, s_ff};
   assign quot_next = {quot_ff[dbpm_pkg::QUOT_W-2:0], div_ge};

   // Digit-by-digit square root, one root bit a step.
   assign r2        = {r_ff, rad_ff[dbpm_pkg::RAD_W-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign sq_ge     = r2 >= trial;
   assign root_next = {root_ff[dbpm_pkg::ROOT_W-2:0], sq_ge};

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      aa_in    = aa_ff;
      dd_in    = dd_ff;
      s_in     = s_ff;
      kl_in    = kl_ff;
      kr_in    = kr_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      rad_in   = rad_ff;
      r_in     = r_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      inv_in   = inv_ff;
      case (state_ff)
         ST_MUL_AA: begin
            aa_in    = mul[dbpm_pkg::SUM_W-1:0];
            state_in = ST_MUL_DD;
         end
         ST_MUL_DD: begin
            dd_in    = mul[dbpm_pkg::SUM_W-1:0];
            state_in = ST_MUL_KL;
         end
         ST_MUL_KL: begin
            kl_in    = dbpm_pkg::PROD_W'(mul);
            state_in = ST_MUL_KR;
         end
         ST_MUL_KR: begin
            kr_in    = dbpm_pkg::PROD_W'(mul);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            s_in = sum;
            if (sum == '0) begin
               inv_in   = '0;
               state_in = ST_DONE;
            end else begin
               rem_in   = '0;
               quot_in  = '0;
               step_in  = dbpm_pkg::STEP_W'(dbpm_pkg::DIV_STEPS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = div_ge ? dbpm_pkg::SUM_W'(rem2 - {1'b0, s_ff})
                             : rem2[dbpm_pkg::SUM_W-1:0];
            quot_in = quot_next;
            if (step_ff == '0) begin
               rad_in   = {1'b0, quot_next};
               r_in     = '0;
               root_in  = '0;
               step_in  = dbpm_pkg::STEP_W'(dbpm_pkg::SQRT_STEPS - 1);
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff - dbpm_pkg::STEP_W'(1);
            end
         end
         ST_SQRT: begin
            r_in    = sq_ge ? dbpm_pkg::REM_SQ_W'(r2 - trial) : r2[dbpm_pkg::REM_SQ_W-1:0];
            root_in = root_next;
            rad_in  = rad_ff << 2;
            if (step_ff == '0) begin
               inv_in   = root_next;
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - dbpm_pkg::STEP_W'(1);
            end
         end
         ST_DONE: ;
         default: state_in = ST_MUL_AA;
      endcase
      // A register write starts the whole derivation over.
      if (write_ok) begin
         state_in = ST_MUL_AA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MUL_AA;
      end else begin
         state_ff <= state_in;
      end
      aa_ff   <= aa_in;
      dd_ff   <= dd_in;
      s_ff    <= s_in;
      kl_ff   <= kl_in;
      kr_ff   <= kr_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      rad_ff  <= rad_in;
      r_ff    <= r_in;
      root_ff <= root_in;
      step_ff <= step_in;
      inv_ff  <= inv_in;
   end

   assign busy = state_ff != ST_DONE;

   always_comb begin
      cfg.row_count      = row_count_ff;
      cfg.column_count   = column_count_ff;
      cfg.hard_mode      = hard_mode_ff;
      cfg.penalty_weight = penalty_weight_ff;
      cfg.a              = a;
      cfg.d              = d;
      cfg.abs_d          = abs_d;
      cfg.lc             = lc;
      cfg.rc             = rc;
      cfg.kl             = kl_ff;
      cfg.kr             = kr_ff;
      cfg.inverse        = inv_ff;
   end

endmodule

// ===== rtl/core/dbpm_front.sv =====
// Front: takes cells, tracks row and column, and forms the boundary line terms.
module dbpm_front #(
   parameter int MAX_DIM = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dbpm_pkg::cfg_type               cfg,
   input  logic                            cfg_busy,
   input  logic                            restart,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dbpm_pkg::SIM_W-1:0]      req_tdata,
   input  logic                            queue_full,
   output logic                            push,
   output dbpm_pkg::entry_type             push_entry
);

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int CNT_W = (POS_W + 1 > dbpm_pkg::COUNT_W) ? POS_W + 1 : dbpm_pkg::COUNT_W;
   localparam int XW    = (POS_W + 1 > dbpm_pkg::DIFF_W) ? POS_W + 1 : dbpm_pkg::DIFF_W;

   logic [POS_W-1:0]                   col_ff, col_in, row_ff, row_in;
   logic signed [dbpm_pkg::PROD_W-1:0] ax_ff, ax_in, dy_ff, dy_in;
   logic [CNT_W-1:0]                   col_plus, row_plus;
   logic                               last_col, last_row, accept;
   logic signed [XW-1:0]               x_s, lc_s, rc_s;

   assign req_tready = !cfg_busy && !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept;

   // End of a row and of the matrix, limited by the counts and by the largest size.
   assign col_plus = CNT_W'(col_ff) + CNT_W'(1);
   assign row_plus = CNT_W'(row_ff) + CNT_W'(1);
   assign last_col = (col_plus >= CNT_W'(cfg.column_count)) || (col_plus >= CNT_W'(MAX_DIM));
   assign last_row = (row_plus >= CNT_W'(cfg.row_count)) || (row_plus >= CNT_W'(MAX_DIM));

   // Position counters; a*x and d*y are kept as running sums along them.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      ax_in  = ax_ff;
      dy_in  = dy_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            ax_in  = '0;
            if (last_row) begin
               row_in = '0;
               dy_in  = '0;
            end else begin
               row_in = row_ff + POS_W'(1);
               dy_in  = dy_ff + dbpm_pkg::PROD_W'(cfg.d);
            end
         end else begin
            col_in = col_ff + POS_W'(1);
            ax_in  = ax_ff + dbpm_pkg::PROD_W'(cfg.a);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
         ax_ff  <= '0;
         dy_ff  <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         ax_ff  <= ax_in;
         dy_ff  <= dy_in;
      end
   end

   // Column test for a vertical band.
   assign x_s  = XW'($signed({1'b0, col_ff}));
   assign lc_s = XW'(cfg.lc);
   assign rc_s = XW'(cfg.rc);

   // Signed distances (scaled) of this cell from the left and right boundary lines.
   always_comb begin
      push_entry.sim        = signed'(req_tdata);
      push_entry.nl         = ax_ff - cfg.kl - dy_ff;
      push_entry.nr         = ax_ff - cfg.kr - dy_ff;
      push_entry.row_zero   = row_ff == '0;
      push_entry.col_inside = (x_s >= lc_s) && (x_s <= rc_s);
      push_entry.last       = last_col && last_row;
   end

endmodule

// ===== rtl/core/dbpm_queue.sv =====
// Short queue of classified cells between the front and the back.
module dbpm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dbpm_pkg::entry_type  push_entry,
   input  logic                 pop,
   output dbpm_pkg::entry_type  pop_entry,
   output logic                 empty,
   output logic                 full
);

   dbpm_pkg::entry_type             slot_ff [dbpm_pkg::QUEUE_DEPTH];
   logic [dbpm_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [dbpm_pkg::QPTR_W:0]       count_ff;

   assign empty     = count_ff == '0;
   assign full      = count_ff == (dbpm_pkg::QPTR_W + 1)'(dbpm_pkg::QUEUE_DEPTH);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + dbpm_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + dbpm_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (dbpm_pkg::QPTR_W + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (dbpm_pkg::QPTR_W + 1)'(1);
         end
      end
   end

endmodule

// ===== rtl/core/dbpm_back.sv =====
// Back: decides the mask, scales it by the weight and adds it to the similarity.
module dbpm_back (
   input  logic                            clock,
   input  logic                            reset,
   input  dbpm_pkg::cfg_type               cfg,
   input  dbpm_pkg::entry_type             pop_entry,
   input  logic                            queue_empty,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dbpm_pkg::SIM_W-1:0]      rsp_sim,
   output logic [dbpm_pkg::MASK_W-1:0]     rsp_mask,
   output logic                            rsp_tlast
);

   localparam int P_W        = dbpm_pkg::MAG_W + dbpm_pkg::INV_W;
   localparam int MASK_SHIFT = dbpm_pkg::INV_FRAC - dbpm_pkg::FRAC_BITS;
   localparam logic [P_W:0] MASK_HALF = (P_W + 1)'(1) << (MASK_SHIFT - 1);
   localparam logic signed [63:0] PROD_HALF = 64'sd1 <<< (dbpm_pkg::FRAC_BITS - 1);
   localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

   logic                               adv;
   // Stage 1: classification.
   logic                               v1_ff, mask_one1_ff, soft1_ff, last1_ff;
   logic [dbpm_pkg::MAG_W-1:0]         mag1_ff;
   logic signed [dbpm_pkg::SIM_W-1:0]  sim1_ff;
   // Stage 2: distance times inverse line length.
   logic                               v2_ff, mask_one2_ff, soft2_ff, last2_ff;
   logic [P_W-1:0]                     p2_ff;
   logic signed [dbpm_pkg::SIM_W-1:0]  sim2_ff;
   // Stage 3: mask value.
   logic                               v3_ff, last3_ff;
   logic [dbpm_pkg::MASK_W-1:0]        mask3_ff;
   logic signed [dbpm_pkg::SIM_W-1:0]  sim3_ff;
   // Stage 4: weight times mask.
   logic                               v4_ff, last4_ff;
   logic [dbpm_pkg::MASK_W-1:0]        mask4_ff;
   logic signed [63:0]                 prod4_ff;
   logic signed [dbpm_pkg::SIM_W-1:0]  sim4_ff;
   // Output register.
   logic                               out_valid_ff, out_last_ff;
   logic [dbpm_pkg::MASK_W-1:0]        out_mask_ff;
   logic [dbpm_pkg::SIM_W-1:0]         out_sim_ff;

   logic signed [dbpm_pkg::PROD_W-1:0] abs_d_s, snl, snr, neg_nl, mag_s;
   logic                               left_ok, hard_inside, soft_out;
   logic [P_W-1:0]                     p_in;
   logic [P_W:0]                       p_rnd, p_shift;
   logic [dbpm_pkg::MASK_W-1:0]        mask_in;
   logic signed [63:0]                 prod_in, rounded, total;
   logic [dbpm_pkg::SIM_W-1:0]         sat_sum;

   // The whole pipe moves while the output register is free or being emptied.
   assign adv = !out_valid_ff || rsp_tready;
   assign pop = adv && !queue_empty;

   // Band test without division: the line terms are compared after taking the
   // sign of the column drift out. Row zero needs the strict form of the left test.
   assign abs_d_s = signed'(dbpm_pkg::PROD_W'(cfg.abs_d));
   assign snl     = (cfg.d < 0) ? -pop_entry.nl : pop_entry.nl;
   assign snr     = (cfg.d < 0) ? -pop_entry.nr : pop_entry.nr;
   assign left_ok = pop_entry.row_zero ? ((snl + abs_d_s) > 0) : (snl >= 0);
   assign hard_inside = (cfg.d == 0) ? pop_entry.col_inside : (left_ok && (snr < abs_d_s));

   // Distance mode: outside when left of the left line or right of the right line.
   assign soft_out = (pop_entry.nl < 0) || (pop_entry.nr > 0);
   assign neg_nl   = -pop_entry.nl;
   assign mag_s    = (pop_entry.nl < 0) ? neg_nl : pop_entry.nr;

   assign p_in = mag1_ff * cfg.inverse;

   // Round the Q.31 product to the mask format and clip it.
   assign p_rnd   = {1'b0, p2_ff} + MASK_HALF;
   assign p_shift = p_rnd >> MASK_SHIFT;

   always_comb begin
      if (soft2_ff) begin
         mask_in = (|p_shift[P_W:dbpm_pkg::MASK_W]) ? dbpm_pkg::MASK_MAX
                                                    : p_shift[dbpm_pkg::MASK_W-1:0];
      end else if (mask_one2_ff) begin
         mask_in = dbpm_pkg::MASK_ONE;
      end else begin
         mask_in = '0;
      end
   end

   assign prod_in = cfg.penalty_weight * signed'({1'b0, mask3_ff});

   // Round the penalty to Q16.16, add and saturate.
   assign rounded = (prod4_ff + PROD_HALF) >>> dbpm_pkg::FRAC_BITS;
   assign total   = 64'(sim4_ff) + rounded;

   always_comb begin
      if (total > SAT_MAX) begin
         sat_sum = dbpm_pkg::SIM_W'(SAT_MAX);
      end else if (total < SAT_MIN) begin
         sat_sum = dbpm_pkg::SIM_W'(SAT_MIN);
      end else begin
         sat_sum = total[dbpm_pkg::SIM_W-1:0];
      end
   end

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= pop;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_valid_ff <= v4_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (adv) begin
         mask_one1_ff <= cfg.hard_mode && !hard_inside;
         soft1_ff     <= !cfg.hard_mode && soft_out;
         mag1_ff      <= mag_s[dbpm_pkg::MAG_W-1:0];
         sim1_ff      <= pop_entry.sim;
         last1_ff     <= pop_entry.last;

         mask_one2_ff <= mask_one1_ff;
         soft2_ff     <= soft1_ff;
         p2_ff        <= p_in;
         sim2_ff      <= sim1_ff;
         last2_ff     <= last1_ff;

         mask3_ff     <= mask_in;
         sim3_ff      <= sim2_ff;
         last3_ff     <= last2_ff;

         prod4_ff     <= prod_in;
         mask4_ff     <= mask3_ff;
         sim4_ff      <= sim3_ff;
         last4_ff     <= last3_ff;

         out_sim_ff   <= sat_sum;
         out_mask_ff  <= mask4_ff;
         out_last_ff  <= last4_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_sim    = out_sim_ff;
   assign rsp_mask   = out_mask_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/core/diagonal_band_penalty_mask.sv =====
// Diagonal band penalty mask: takes similarity-matrix cells in row-major order and
// adds a weighted penalty for cells outside a diagonal band of half-width
// band_half_width around the line from top_column at row 0 to bottom_column at the
// last row. Hard mode penalizes with a mask of 1.0, distance mode with the
// perpendicular distance to the crossed boundary. The sustained rate is one cell per
// clock while the output is not stalled and no derivation is running. A five-stage
// back pipeline with two multipliers follows the classifying front, and a four-entry
// queue lets either side stall alone. After reset and after every register write the
// block derives the inverse line length with a shared multiplier, a bit-serial divider
// and a bit-serial square root: req_tready stays low until it is done, while register
// writes are still taken. A register write also restarts the row and column count at
// the first cell. The user must write registers only while no cell is in flight; the
// block itself does not enforce it.
module diagonal_band_penalty_mask #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // [31:0] similarity
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [63:0]                         rsp_tdata,   // [31:0] constrained_similarity,
                                                            // [62:32] mask_value, [63] zero
   output logic                                rsp_tlast,   // matrix_end
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dbpm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dbpm_pkg::CSR_DATA_W-1:0]     csr_data
);

   dbpm_pkg::cfg_type               cfg;
   dbpm_pkg::entry_type             push_entry, pop_entry;
   logic                            cfg_busy, restart;
   logic                            push, pop, queue_empty, queue_full;
   logic [dbpm_pkg::SIM_W-1:0]      rsp_sim;
   logic [dbpm_pkg::MASK_W-1:0]     rsp_mask;

   // Registers and derived band constants.
   dbpm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .busy      (cfg_busy),
      .restart   (restart)
   );

   // Cell intake and position tracking.
   dbpm_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cfg_busy   (cfg_busy),
      .restart    (restart),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue.
   dbpm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   // Mask and penalty arithmetic.
   dbpm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .pop_entry   (pop_entry),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_sim     (rsp_sim),
      .rsp_mask    (rsp_mask),
      .rsp_tlast   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_mask, rsp_sim};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking stream testbench for the diagonal band penalty mask.
module tb;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_CELLS = 1950;
   localparam logic [dbpm_pkg::CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   // One expected result beat.
   typedef struct packed {
      logic [dbpm_pkg::SIM_W-1:0]  similarity_out;
      logic [dbpm_pkg::MASK_W-1:0] mask;
      logic                        matrix_end;
   } beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] similarity
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [31:0] constrained_similarity, [62:32] mask_value, [63] zero
   logic rsp_tlast;                // matrix_end
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [dbpm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [dbpm_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the configuration and the cell position.
   logic [dbpm_pkg::COUNT_W-1:0]         m_rows;
   logic [dbpm_pkg::COUNT_W-1:0]         m_cols;
   logic signed [dbpm_pkg::COLUMN_W-1:0] m_top;
   logic signed [dbpm_pkg::COLUMN_W-1:0] m_bottom;
   logic [dbpm_pkg::HALF_W-1:0]          m_half;
   logic                                 m_hard;
   logic signed [dbpm_pkg::WEIGHT_W-1:0] m_weight;
   longint unsigned                      m_inverse;
   int                                   m_row;
   int                                   m_col;

   logic [31:0] similarity_backlog[$];
   beat_type    cells_due[$];

   bit no_idle = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int cells_queued = 0;
   int cells_checked = 0;
   int cells_outside = 0;
   int settings_run = 0;
   int errors = 0;
   int cycle_count = 0;

   diagonal_band_penalty_mask DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Inverse of the centre line length in Q1.31: floor of the square root of 2^62 / L^2.
   function automatic longint unsigned inverse_line_length();
      longint a, d;
      longint unsigned s, lim, lo, hi, mid;
      a = longint'(m_rows) - 1;
      d = longint'(m_bottom) - longint'(m_top);
      s = a * a + d * d;
      if (s == 0) return 0;
      lim = (64'd1 << 62) / s;
      lo = 0;
      hi = 64'd1 << 31;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (mid * mid <= lim) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   // Penalized value, mask and matrix end of the next cell; advances the position.
   function automatic beat_type penalize_cell(input logic signed [31:0] sim);
      longint x, y, a, top, d, lc, rc, ql, qr, nl, nr, prod, total;
      longint unsigned mag, p, mask;
      bit in_band, last_col, last_row;
      beat_type predicted;
      x = m_col;
      y = m_row;
      a = longint'(m_rows) - 1;
      top = m_top;
      d = longint'(m_bottom) - top;
      lc = top - longint'(m_half);
      rc = top + longint'(m_half);
      mask = 0;
      if (m_hard) begin
         // A vertical band compares the column directly against both boundaries.
         if (d == 0) begin
            in_band = (x >= lc) && (x <= rc);
         end else begin
            ql = (a * (x - lc)) / d;
            qr = (a * (x - rc)) / d;
            in_band = (y - ql <= 0) && (y - qr >= 0);
         end
         mask = in_band ? 0 : (64'd1 << dbpm_pkg::FRAC_BITS);
      end else begin
         nl = a * (x - lc) - d * y;
         nr = a * (x - rc) - d * y;
         if (!(nl >= 0 && nr <= 0)) begin
            mag = (nl < 0) ? -nl : nr;
            p = mag * m_inverse;
            mask = (p + (64'd1 << (30 - dbpm_pkg::FRAC_BITS))) >> (31 - dbpm_pkg::FRAC_BITS);
            if (mask > 64'h7FFF_FFFF) mask = 64'h7FFF_FFFF;
         end
      end

      // Weighted penalty rounded half up to Q16.16, then a saturating add.
      prod = longint'(m_weight) * longint'(mask);
      prod = (prod + (64'sd1 <<< (dbpm_pkg::FRAC_BITS - 1))) >>> dbpm_pkg::FRAC_BITS;
      total = longint'(sim) + prod;
      if (total > SAT_HI) total = SAT_HI;
      if (total < SAT_LO) total = SAT_LO;

      last_col = (m_col + 1 >= m_cols) || (m_col + 1 >= 4096);
      last_row = (m_row + 1 >= m_rows) || (m_row + 1 >= 4096);
      if (last_col) begin
         m_col = 0;
         m_row = last_row ? 0 : m_row + 1;
      end else begin
         m_col = m_col + 1;
      end

      predicted.similarity_out = total[31:0];
      predicted.mask = mask[30:0];
      predicted.matrix_end = last_col && last_row;
      return predicted;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [31:0] random_similarity();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom_range(0, 1 << 20) - (1 << 19);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] extreme_similarity(input int i);
      case (i % 5)
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'h0000_0001;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Random register contents, mostly small geometry so that the band crosses the matrix.
   function automatic logic [31:0] random_register(
      input logic [dbpm_pkg::CSR_INDEX_W-1:0] idx
   );
      int r, span;
      r = $urandom_range(0, 9);
      span = (m_cols > 40) ? 40 : m_cols;
      case (idx)
         dbpm_pkg::REG_ROW_COUNT:
            return (r == 0) ? 2 : (r == 1) ? 4096 : $urandom_range(2, 9);
         dbpm_pkg::REG_COLUMN_COUNT:
            return (r == 0) ? 1 : (r == 1) ? 4096 : $urandom_range(1, 12);
         dbpm_pkg::REG_TOP_COLUMN, dbpm_pkg::REG_BOTTOM_COLUMN: begin
            if (r == 0) return -8192;
            if (r == 1) return 8191;
            if (idx == dbpm_pkg::REG_BOTTOM_COLUMN && r < 5) return 32'(m_top);
            return int'($urandom_range(0, span + 3)) - 2;
         end
         dbpm_pkg::REG_BAND_HALF_WIDTH:
            return (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(0, 3);
         dbpm_pkg::REG_HARD_MODE:
            return $urandom_range(0, 1);
         dbpm_pkg::REG_PENALTY_WEIGHT: begin
            if (r == 0) return 32'h7FFF_FFFF;
            if (r == 1) return 32'h8000_0000;
            if (r < 4) return $urandom();
            return $urandom_range(0, 1 << 19) - (1 << 18);
         end
         default:
            return $urandom();
      endcase
   endfunction

   // One register beat; the shadow copy follows once the write is taken.
   task automatic write_reg(input logic [dbpm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         dbpm_pkg::REG_ROW_COUNT:       m_rows = value[dbpm_pkg::COUNT_W-1:0];
         dbpm_pkg::REG_COLUMN_COUNT:    m_cols = value[dbpm_pkg::COUNT_W-1:0];
         dbpm_pkg::REG_TOP_COLUMN:      m_top = value[dbpm_pkg::COLUMN_W-1:0];
         dbpm_pkg::REG_BOTTOM_COLUMN:   m_bottom = value[dbpm_pkg::COLUMN_W-1:0];
         dbpm_pkg::REG_BAND_HALF_WIDTH: m_half = value[dbpm_pkg::HALF_W-1:0];
         dbpm_pkg::REG_HARD_MODE:       m_hard = value[0];
         dbpm_pkg::REG_PENALTY_WEIGHT:  m_weight = value;
         default: return;
      endcase
      m_inverse = inverse_line_length();
      m_row = 0;
      m_col = 0;
   endtask

   task automatic queue_cells(input int n, input bit directed);
      @(negedge clock);
      for (int i = 0; i < n; i++)
         similarity_backlog.push_back(directed ? extreme_similarity(i) : random_similarity());
      cells_queued += n;
   endtask

   // Sampled on the falling edge so that every beat of the rising edge has settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (similarity_backlog.size() != 0 || req_tvalid || cells_due.size() != 0);
   endtask

   // Request side: takes the next similarity from the backlog after a random gap.
   always @(posedge clock) begin
      beat_type predicted;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted = penalize_cell(req_tdata);
            if (predicted.mask != 0) cells_outside++;
            cells_due.push_back(predicted);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (similarity_backlog.size() != 0) begin
               req_tdata <= similarity_backlog.pop_front();
               req_tvalid <= 1'b1;
               gap_left <= no_idle ? 0 : idle_length();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side: compares each beat with the oldest expected cell and stalls at random.
   always @(posedge clock) begin
      beat_type due;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (cells_due.size() == 0) begin
               $display("%0t: result beat %h last %b with no cell outstanding",
                        $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               due = cells_due.pop_front();
               if (rsp_tdata[31:0] !== due.similarity_out) begin
                  $display("%0t: cell %0d constrained_similarity expected %h got %h",
                           $time, cells_checked, due.similarity_out, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[62:32] !== due.mask) begin
                  $display("%0t: cell %0d mask_value expected %h got %h",
                           $time, cells_checked, due.mask, rsp_tdata[62:32]);
                  errors++;
               end
               if (rsp_tlast !== due.matrix_end) begin
                  $display("%0t: cell %0d matrix_end expected %b got %b",
                           $time, cells_checked, due.matrix_end, rsp_tlast);
                  errors++;
               end
               if (rsp_tdata[63] !== 1'b0) begin
                  $display("%0t: cell %0d padding bit expected 0 got %b",
                           $time, cells_checked, rsp_tdata[63]);
                  errors++;
               end
               cells_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left <= no_idle ? 0 : idle_length();
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // Stimulus sequence: directed settings first, then random settings.
   initial begin
      logic [dbpm_pkg::CSR_INDEX_W-1:0] order[7];
      logic [dbpm_pkg::CSR_INDEX_W-1:0] swap;
      int choice, n, cap, j;
      bit paused_once;
      paused_once = 1'b0;

      m_rows = 2;
      m_cols = 1;
      m_top = 0;
      m_bottom = 0;
      m_half = 0;
      m_hard = 1'b1;
      m_weight = 0;
      m_inverse = inverse_line_length();
      m_row = 0;
      m_col = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Settings after reset: a one-column band on a one-column matrix.
      queue_cells(2, 1'b1);
      wait_drained();
      settings_run++;

      // Binary mask on a sloped band with the largest weight, then the smallest.
      write_reg(dbpm_pkg::REG_ROW_COUNT, 3);
      write_reg(dbpm_pkg::REG_COLUMN_COUNT, 5);
      write_reg(dbpm_pkg::REG_TOP_COLUMN, 1);
      write_reg(dbpm_pkg::REG_BOTTOM_COLUMN, 3);
      write_reg(dbpm_pkg::REG_BAND_HALF_WIDTH, 0);
      write_reg(dbpm_pkg::REG_HARD_MODE, 1);
      write_reg(dbpm_pkg::REG_PENALTY_WEIGHT, 32'h7FFF_FFFF);
      queue_cells(15, 1'b1);
      wait_drained();
      write_reg(dbpm_pkg::REG_PENALTY_WEIGHT, 32'h8000_0000);
      queue_cells(5, 1'b1);
      wait_drained();

      // Distance mask on the same band.
      write_reg(dbpm_pkg::REG_HARD_MODE, 0);
      queue_cells(3, 1'b1);
      wait_drained();
      settings_run += 3;

      while (cells_queued < RANDOM_CELLS + 25) begin
         choice = $urandom_range(0, 7);
         if (choice == 0) begin
            // An unused index must leave both the settings and the position alone.
            write_reg(REG_UNUSED, $urandom());
         end else if (choice <= 2) begin
            order[0] = dbpm_pkg::CSR_INDEX_W'($urandom_range(dbpm_pkg::REG_ROW_COUNT,
                                                             dbpm_pkg::REG_PENALTY_WEIGHT));
            write_reg(order[0], random_register(order[0]));
         end else begin
            for (int i = 0; i < 7; i++) order[i] = dbpm_pkg::CSR_INDEX_W'(i);
            for (int i = 6; i > 0; i--) begin
               j = $urandom_range(0, i);
               swap = order[i];
               order[i] = order[j];
               order[j] = swap;
            end
            for (int i = 0; i < 7; i++) write_reg(order[i], random_register(order[i]));
         end
         settings_run++;

         no_idle = ($urandom_range(0, 4) == 0);
         cap = 2 * int'(m_rows) * int'(m_cols);
         if (cap > 90) cap = 90;
         n = $urandom_range(1, cap);
         queue_cells(n / 2, 1'b0);
         // At the first pause and then at random, the sender holds off until every outstanding result is back.
         if (!paused_once || $urandom_range(0, 3) == 0) begin
            wait_drained();
            paused_once = 1'b1;
         end
         queue_cells(n - n / 2, 1'b0);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("Checked %0d cells over %0d register settings, binary and distance masks.",
               cells_checked, settings_run);
      $display("%0d of them fell outside the band.", cells_outside);
      if (errors == 0 && cells_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
